@@ design/wldb_pkg.sv @@
// Package for the antialiased line raster block: item layouts, descriptor passed
// from the front end to the back end, command and register codes, helpers.
// No dependencies.
package wldb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int IN_W           = 144;
  localparam int OUT_W          = 56;
  localparam int CFG_ADDR_W     = 4;
  localparam int DIV_NUM_W      = 24;
  localparam int DIV_DEN_W      = 13;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [23:0] DEPTH_EMPTY  = 24'h7FFFFF;
  localparam logic [31:0] COLOUR_RESET = 32'h000000FF;
  localparam logic [10:0] DIM_RESET    = 11'd1024;
  localparam logic [15:0] TOL_RESET    = 16'd655;
  localparam logic [8:0]  SCALE_ONE    = 9'd256;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_DEPTH_TOL    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  pad;
    logic [8:0]  cov_scale;
    logic [7:0]  alpha;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [23:0] end_depth;
    logic [12:0] end_y;
    logic [12:0] end_x;
    logic [23:0] start_depth;
    logic [12:0] start_y;
    logic [12:0] start_x;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_depth;
    logic [7:0]  pixel_alpha;
    logic [7:0]  pixel_blue;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_red;
  } out_item_t;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [15:0] depth_tol;
  } cfg_t;

  // Line setup: ordered endpoints and floor quotient/remainder steps per column.
  typedef struct packed {
    op_t         op;
    logic        steep;
    logic [12:0] x0;
    logic [12:0] y0;
    logic [23:0] z0;
    logic [12:0] dx;
    logic [12:0] count;
    logic [13:0] qy;
    logic [12:0] ry;
    logic [7:0]  fq;
    logic [12:0] fr;
    logic [24:0] qz;
    logic [12:0] rz;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [8:0]  scale;
  } desc_t;

  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [24:0] prod;
    logic [8:0]  q;
    logic [16:0] r;
    prod = 25'(v) * 25'd257;
    q    = prod[24:16];
    r    = 17'(v) - 17'(q) * 17'd255;
    if (r >= 17'd255) begin
      q = q + 9'd1;
    end
    return q[7:0];
  endfunction

  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

@@ design/wu_line_depth_blend_raster_core.sv @@
// Antialiased line rasterizer with colour and depth stores.
// Input channel: tuser = opcode (0 clear, 1 draw line, 2 read pixel, 3 no-op);
// tdata = line endpoints, depths, colour and coverage scale. Every command
// returns exactly one transfer on the output channel: the stored pixel for a
// read in the frame (zero colour, empty depth outside it), all zeros otherwise.
// A draw is set up in the front end with up to three divisions, then drawn in
// the back end, which reads and writes the stores one pixel at a time; a
// clear sweeps all MAX_WIDTH*MAX_HEIGHT store words, one store word per cycle.
// A two-entry queue lets the front end set up the next line while the back end
// still draws. After reset the same clear sweep runs before the first command
// is carried out; commands are still taken into the queue and configuration
// writes are taken at any time.
// If the receiver stalls, the result waits in the output register, the back
// end holds its next result, and the queue and front end fill, after which
// in_tready stays low. Configuration is over the APB port: width, height,
// depth tolerance. Depends on wldb_pkg, wldb_front, wldb_queue, wldb_back.
module wu_line_depth_blend_raster_core #(
  parameter int MAX_WIDTH  = wldb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wldb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_x, start_y, start_depth, end_x, end_y, end_depth, red, green, blue,
  // alpha, cov_scale, zero pad
  input  logic [wldb_pkg::IN_W-1:0]         in_tdata,
  // opcode
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_red, pixel_green, pixel_blue, pixel_alpha, pixel_depth
  output logic [wldb_pkg::OUT_W-1:0]        out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wldb_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import wldb_pkg::*;

  logic [10:0] fw_r, fw_nxt;
  logic [10:0] fh_r, fh_nxt;
  logic [15:0] tol_r, tol_nxt;
  logic        wr_en;
  reg_idx_t    ridx;
  cfg_t        cfg;

  logic  q_push, q_full, q_pop, q_empty;
  desc_t q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign ridx       = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    fw_nxt  = fw_r;
    fh_nxt  = fh_r;
    tol_nxt = tol_r;
    if (wr_en) begin
      unique case (ridx)
        REG_FRAME_WIDTH:  fw_nxt  = cfg_pwdata[10:0];
        REG_FRAME_HEIGHT: fh_nxt  = cfg_pwdata[10:0];
        REG_DEPTH_TOL:    tol_nxt = cfg_pwdata[15:0];
        default: ;
      endcase
    end
    unique case (ridx)
      REG_FRAME_WIDTH:  cfg_prdata = {21'd0, fw_r};
      REG_FRAME_HEIGHT: cfg_prdata = {21'd0, fh_r};
      REG_DEPTH_TOL:    cfg_prdata = {16'd0, tol_r};
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= DIM_RESET;
      fh_r  <= DIM_RESET;
      tol_r <= TOL_RESET;
    end else begin
      fw_r  <= fw_nxt;
      fh_r  <= fh_nxt;
      tol_r <= tol_nxt;
    end
  end

  assign cfg.frame_width  = fw_r;
  assign cfg.frame_height = fh_r;
  assign cfg.depth_tol    = tol_r;

  wldb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  wldb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  wldb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ design/wldb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wldb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/wldb_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on wldb_pkg.
module wldb_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [wldb_pkg::DIV_NUM_W-1:0]   num,
  input  logic [wldb_pkg::DIV_DEN_W-1:0]   den,
  output logic                             done,
  output logic [wldb_pkg::DIV_NUM_W-1:0]   quo,
  output logic [wldb_pkg::DIV_DEN_W-1:0]   rem
);
  import wldb_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W:0]   sh;
  logic                 ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    sh       = {rem_r, num_r[DIV_NUM_W-1]};
    ge       = sh >= {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_DEN_W'(sh - {1'b0, den_r}) : sh[DIV_DEN_W-1:0];
      num_nxt = {num_r[DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DIV_NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule

@@ design/wldb_queue.sv @@
// Two-entry command queue between the setup front end and the pixel back end.
// Depends on wldb_pkg.
module wldb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wldb_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output wldb_pkg::desc_t pop_data,
  output logic            empty
);
  import wldb_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  desc_t           mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = cnt_r == (PW+1)'(QUEUE_DEPTH);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? PW'(wp_r + PW'(1)) : wp_r;
    rp_nxt  = do_pop ? PW'(rp_r + PW'(1)) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

@@ design/wldb_front.sv @@
// Front end: takes command transfers, orders line endpoints and runs the
// floor divisions for the per-column steps. Depends on wldb_pkg, wldb_div.
module wldb_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [wldb_pkg::IN_W-1:0] in_tdata,
  input  logic [1:0]                in_tuser,
  output logic                      q_push,
  output wldb_pkg::desc_t           q_data,
  input  logic                      q_full
);
  import wldb_pkg::*;

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_SETUP = 6'b000010,
    F_DY    = 6'b000100,
    F_DF    = 6'b001000,
    F_DZ    = 6'b010000,
    F_PUSH  = 6'b100000
  } fstate_t;

  fstate_t  state_r, state_nxt;
  logic     launch_r, launch_nxt;
  in_item_t it_r, it_nxt;
  op_t      op_r, op_nxt;
  desc_t    desc_r, desc_nxt;
  logic [13:0] dy_r, dy_nxt;
  logic [24:0] dz_r, dz_nxt;

  logic        div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_rem;

  logic [13:0] ddx, ddy, adx, ady;
  logic        steep, swap, neg, fix;
  logic [12:0] ax0, ay0, ax1, ay1, x0, y0, x1, y1;
  logic [23:0] z0, z1;
  logic [13:0] dx_w, dy_mag, qy_mag;
  logic [23:0] dz_mag;
  logic [24:0] qz_mag;

  wldb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (desc_r.dx),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  assign in_tready = state_r == F_IDLE;
  assign q_push    = state_r == F_PUSH;
  assign q_data    = desc_r;

  always_comb begin
    ddx   = {it_r.end_x[12], it_r.end_x} - {it_r.start_x[12], it_r.start_x};
    ddy   = {it_r.end_y[12], it_r.end_y} - {it_r.start_y[12], it_r.start_y};
    adx   = ddx[13] ? 14'(-ddx) : ddx;
    ady   = ddy[13] ? 14'(-ddy) : ddy;
    steep = ady > adx;
    ax0   = steep ? it_r.start_y : it_r.start_x;
    ay0   = steep ? it_r.start_x : it_r.start_y;
    ax1   = steep ? it_r.end_y : it_r.end_x;
    ay1   = steep ? it_r.end_x : it_r.end_y;
    swap  = $signed(ax0) > $signed(ax1);
    x0    = swap ? ax1 : ax0;
    y0    = swap ? ay1 : ay0;
    z0    = swap ? it_r.end_depth : it_r.start_depth;
    x1    = swap ? ax0 : ax1;
    y1    = swap ? ay0 : ay1;
    z1    = swap ? it_r.start_depth : it_r.end_depth;
    dx_w  = {x1[12], x1} - {x0[12], x0};
    dy_mag = dy_r[13] ? 14'(-dy_r) : dy_r;
    dz_mag = dz_r[24] ? 24'(-dz_r) : dz_r[23:0];
  end

  always_comb begin
    unique case (state_r)
      F_DY:    div_num = DIV_NUM_W'(dy_mag);
      F_DF:    div_num = DIV_NUM_W'({desc_r.ry, 8'd0});
      default: div_num = dz_mag;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    launch_nxt = launch_r;
    it_nxt     = it_r;
    op_nxt     = op_r;
    desc_nxt   = desc_r;
    dy_nxt     = dy_r;
    dz_nxt     = dz_r;
    div_start  = 1'b0;
    neg        = 1'b0;
    fix        = 1'b0;
    qy_mag     = '0;
    qz_mag     = '0;
    unique case (state_r)
      F_IDLE: begin
        if (in_tvalid) begin
          it_nxt    = in_item_t'(in_tdata);
          op_nxt    = op_t'(in_tuser);
          state_nxt = F_SETUP;
        end
      end
      F_SETUP: begin
        desc_nxt.op    = op_r;
        desc_nxt.red   = it_r.red;
        desc_nxt.green = it_r.green;
        desc_nxt.blue  = it_r.blue;
        desc_nxt.alpha = it_r.alpha;
        desc_nxt.scale = (it_r.cov_scale > SCALE_ONE) ? SCALE_ONE : it_r.cov_scale;
        desc_nxt.qy    = '0;
        desc_nxt.ry    = '0;
        desc_nxt.fq    = '0;
        desc_nxt.fr    = '0;
        desc_nxt.qz    = '0;
        desc_nxt.rz    = '0;
        desc_nxt.count = 13'd1;
        if (op_r == OP_DRAW) begin
          desc_nxt.steep = steep;
          desc_nxt.x0    = x0;
          desc_nxt.y0    = y0;
          desc_nxt.z0    = z0;
          desc_nxt.dx    = dx_w[12:0];
          if (dx_w != '0) begin
            desc_nxt.count = dx_w[12:0];
          end
          dy_nxt    = {y1[12], y1} - {y0[12], y0};
          dz_nxt    = {z1[23], z1} - {z0[23], z0};
          state_nxt = (dx_w == '0) ? F_PUSH : F_DY;
        end else begin
          desc_nxt.steep = 1'b0;
          desc_nxt.x0    = it_r.start_x;
          desc_nxt.y0    = it_r.start_y;
          desc_nxt.z0    = it_r.start_depth;
          desc_nxt.dx    = '0;
          state_nxt      = F_PUSH;
        end
      end
      F_DY: begin
        if (!launch_r) begin
          div_start  = 1'b1;
          launch_nxt = 1'b1;
        end else if (div_done) begin
          neg         = dy_r[13];
          fix         = neg && (div_rem != '0);
          qy_mag      = div_quo[13:0] + 14'(fix);
          desc_nxt.qy = neg ? 14'(-qy_mag) : qy_mag;
          desc_nxt.ry = fix ? 13'(desc_r.dx - div_rem) : div_rem;
          launch_nxt  = 1'b0;
          state_nxt   = F_DF;
        end
      end
      F_DF: begin
        if (!launch_r) begin
          div_start  = 1'b1;
          launch_nxt = 1'b1;
        end else if (div_done) begin
          desc_nxt.fq = div_quo[7:0];
          desc_nxt.fr = div_rem;
          launch_nxt  = 1'b0;
          state_nxt   = F_DZ;
        end
      end
      F_DZ: begin
        if (!launch_r) begin
          div_start  = 1'b1;
          launch_nxt = 1'b1;
        end else if (div_done) begin
          neg         = dz_r[24];
          fix         = neg && (div_rem != '0);
          qz_mag      = {1'b0, div_quo} + 25'(fix);
          desc_nxt.qz = neg ? 25'(-qz_mag) : qz_mag;
          desc_nxt.rz = fix ? 13'(desc_r.dx - div_rem) : div_rem;
          launch_nxt  = 1'b0;
          state_nxt   = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      launch_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= launch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r   <= it_nxt;
    op_r   <= op_nxt;
    desc_r <= desc_nxt;
    dy_r   <= dy_nxt;
    dz_r   <= dz_nxt;
  end

endmodule

@@ design/wldb_back.sv @@
// Back end: steps columns, does clip, depth test and read-modify-write of both
// stores, clear sweeps and reads; holds the result register. Depends on wldb_pkg, wldb_ram.
module wldb_back #(
  parameter int MAX_WIDTH  = wldb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wldb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wldb_pkg::cfg_t             cfg,
  input  logic                       q_empty,
  input  wldb_pkg::desc_t            q_data,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [wldb_pkg::OUT_W-1:0] out_tdata
);
  import wldb_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int YB    = $clog2(MAX_HEIGHT);

  typedef enum logic [6:0] {
    B_CLEAR = 7'b0000001,
    B_IDLE  = 7'b0000010,
    B_PIX   = 7'b0000100,
    B_RD    = 7'b0001000,
    B_CMP   = 7'b0010000,
    B_WR    = 7'b0100000,
    B_DONE  = 7'b1000000
  } bstate_t;

  bstate_t     state_r, state_nxt;
  logic        clr_cmd_r, clr_cmd_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  desc_t       d_r, d_nxt;
  logic [13:0] col_r, col_nxt, row_r, row_nxt;
  logic [23:0] z_r, z_nxt;
  logic [12:0] k_r, k_nxt, remy_r, remy_nxt, sf_r, sf_nxt, remz_r, remz_nxt;
  logic [7:0]  frac_r, frac_nxt;
  logic        sel_r, sel_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [16:0] wt1_r, wt1_nxt;
  logic [23:0] wt_r, wt_nxt;
  logic [31:0] pr_r, pr_nxt, pg_r, pg_nxt, pb_r, pb_nxt;
  logic        ow_r, ow_nxt;
  logic [31:0] res_col_r, res_col_nxt;
  logic [23:0] res_dep_r, res_dep_nxt;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [13:0]   pix_row, px, py;
  logic          in_frame, adv, last_col, reject;
  logic [8:0]    cov;
  logic [13:0]   remy_sum, sf_sum, remz_sum;
  logic          wy, cf, wz;
  logic [25:0]   zs, st;

  logic          cram_we, dram_we;
  logic [AW-1:0] waddr;
  logic [31:0]   cram_wdata, rd_col;
  logic [23:0]   dram_wdata, rd_dep;

  wldb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_colour_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (waddr),
    .wdata (cram_wdata),
    .raddr (idx_r),
    .rdata (rd_col)
  );

  wldb_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_depth_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (waddr),
    .wdata (dram_wdata),
    .raddr (idx_r),
    .rdata (rd_dep)
  );

  assign eff_w = ({1'b0, cfg.frame_width} > 12'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
                                                            : WW'(cfg.frame_width);
  assign eff_h = ({1'b0, cfg.frame_height} > 12'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                              : HW'(cfg.frame_height);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    pix_row  = row_r + 14'(sel_r);
    px       = d_r.steep ? pix_row : col_r;
    py       = d_r.steep ? col_r : pix_row;
    in_frame = !px[13] && !py[13] && (px[12:0] < 13'(eff_w)) && (py[12:0] < 13'(eff_h));
    cov      = sel_r ? {1'b0, frac_r} : 9'(SCALE_ONE - {1'b0, frac_r});
    remy_sum = {1'b0, remy_r} + {1'b0, d_r.ry};
    wy       = remy_sum >= {1'b0, d_r.dx};
    sf_sum   = {1'b0, sf_r} + {1'b0, d_r.fr};
    cf       = sf_sum >= {1'b0, d_r.dx};
    remz_sum = {1'b0, remz_r} + {1'b0, d_r.rz};
    wz       = remz_sum >= {1'b0, d_r.dx};
    last_col = (14'(k_r) + 14'd1) == {1'b0, d_r.count};
    zs       = {{2{z_r[23]}}, z_r};
    st       = {{2{rd_dep[23]}}, rd_dep} + {10'd0, cfg.depth_tol};
    reject   = $signed(zs) > $signed(st);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cmd_nxt   = clr_cmd_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    d_nxt         = d_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    z_nxt         = z_r;
    k_nxt         = k_r;
    remy_nxt      = remy_r;
    sf_nxt        = sf_r;
    remz_nxt      = remz_r;
    frac_nxt      = frac_r;
    sel_nxt       = sel_r;
    idx_nxt       = idx_r;
    wt1_nxt       = wt1_r;
    wt_nxt        = wt_r;
    pr_nxt        = pr_r;
    pg_nxt        = pg_r;
    pb_nxt        = pb_r;
    ow_nxt        = ow_r;
    res_col_nxt   = res_col_r;
    res_dep_nxt   = res_dep_r;
    q_pop         = 1'b0;
    adv           = 1'b0;
    cram_we       = 1'b0;
    dram_we       = 1'b0;
    waddr         = idx_r;
    cram_wdata    = COLOUR_RESET;
    dram_wdata    = z_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      B_CLEAR: begin
        cram_we     = 1'b1;
        dram_we     = 1'b1;
        waddr       = clr_cnt_r;
        dram_wdata  = DEPTH_EMPTY;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clr_cnt_nxt = '0;
          clr_cmd_nxt = 1'b0;
          state_nxt   = clr_cmd_r ? B_DONE : B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          d_nxt       = q_data;
          col_nxt     = {q_data.x0[12], q_data.x0};
          row_nxt     = {q_data.y0[12], q_data.y0};
          z_nxt       = q_data.z0;
          k_nxt       = '0;
          remy_nxt    = '0;
          sf_nxt      = '0;
          remz_nxt    = '0;
          frac_nxt    = '0;
          sel_nxt     = 1'b0;
          res_col_nxt = '0;
          res_dep_nxt = '0;
          unique case (q_data.op)
            OP_CLEAR: begin
              clr_cmd_nxt = 1'b1;
              state_nxt   = B_CLEAR;
            end
            OP_DRAW, OP_READ: state_nxt = B_PIX;
            default:          state_nxt = B_DONE;
          endcase
        end
      end
      B_PIX: begin
        idx_nxt = AW'(py[YB-1:0]) * AW'(eff_w) + AW'(px[XB-1:0]);
        wt1_nxt = 17'(d_r.alpha) * 17'(cov);
        if (in_frame) begin
          state_nxt = B_RD;
        end else if (d_r.op == OP_READ) begin
          res_dep_nxt = DEPTH_EMPTY;
          state_nxt   = B_DONE;
        end else begin
          adv = 1'b1;
        end
      end
      B_RD: begin
        wt_nxt    = 24'(wt1_r) * 24'(d_r.scale);
        state_nxt = B_CMP;
      end
      B_CMP: begin
        if (d_r.op == OP_READ) begin
          res_col_nxt = rd_col;
          res_dep_nxt = rd_dep;
          state_nxt   = B_DONE;
        end else if (reject) begin
          adv = 1'b1;
        end else begin
          pr_nxt    = 32'(d_r.red) * 32'(wt_r);
          pg_nxt    = 32'(d_r.green) * 32'(wt_r);
          pb_nxt    = 32'(d_r.blue) * 32'(wt_r);
          ow_nxt    = $signed(z_r) < $signed(rd_dep);
          state_nxt = B_WR;
        end
      end
      B_WR: begin
        cram_we = 1'b1;
        dram_we = ow_r;
        if (ow_r) begin
          cram_wdata = {div255(pr_r[31:16]), div255(pg_r[31:16]),
                        div255(pb_r[31:16]), wt_r[23:16]};
        end else begin
          cram_wdata = {sat_add8(rd_col[31:24], div255({1'b0, pr_r[31:17]})),
                        sat_add8(rd_col[23:16], div255({1'b0, pg_r[31:17]})),
                        sat_add8(rd_col[15:8], div255({1'b0, pb_r[31:17]})),
                        sat_add8(rd_col[7:0], div255({1'b0, wt_r[23:9]}))};
        end
        adv = 1'b1;
      end
      B_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.pixel_red   = res_col_r[31:24];
          out_data_nxt.pixel_green = res_col_r[23:16];
          out_data_nxt.pixel_blue  = res_col_r[15:8];
          out_data_nxt.pixel_alpha = res_col_r[7:0];
          out_data_nxt.pixel_depth = res_dep_r;
          state_nxt                = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    if (adv) begin
      if (!sel_r) begin
        sel_nxt   = 1'b1;
        state_nxt = B_PIX;
      end else begin
        sel_nxt = 1'b0;
        if (last_col) begin
          state_nxt = B_DONE;
        end else begin
          k_nxt     = k_r + 13'd1;
          col_nxt   = col_r + 14'd1;
          row_nxt   = row_r + d_r.qy + 14'(wy);
          remy_nxt  = wy ? 13'(remy_sum - {1'b0, d_r.dx}) : remy_sum[12:0];
          frac_nxt  = frac_r + d_r.fq + 8'(cf);
          sf_nxt    = cf ? 13'(sf_sum - {1'b0, d_r.dx}) : sf_sum[12:0];
          z_nxt     = 24'({z_r[23], z_r} + d_r.qz + 25'(wz));
          remz_nxt  = wz ? 13'(remz_sum - {1'b0, d_r.dx}) : remz_sum[12:0];
          state_nxt = B_PIX;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cmd_r   <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    d_r        <= d_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    z_r        <= z_nxt;
    k_r        <= k_nxt;
    remy_r     <= remy_nxt;
    sf_r       <= sf_nxt;
    remz_r     <= remz_nxt;
    frac_r     <= frac_nxt;
    sel_r      <= sel_nxt;
    idx_r      <= idx_nxt;
    wt1_r      <= wt1_nxt;
    wt_r       <= wt_nxt;
    pr_r       <= pr_nxt;
    pg_r       <= pg_nxt;
    pb_r       <= pb_nxt;
    ow_r       <= ow_nxt;
    res_col_r  <= res_col_nxt;
    res_dep_r  <= res_dep_nxt;
  end

endmodule
